[rtl/cb85_pkg.sv]
// ----------------------------------------------------------------------------
// cb85_pkg
// Types, constants and the digit alphabet shared by the base-85 record decoder.
// ----------------------------------------------------------------------------
package cb85_pkg;

    localparam int unsigned RADIX            = 85;
    localparam int unsigned DIGITS_PER_VALUE = 5;
    localparam int unsigned WORDS_PER_RECORD = 256 / 32;
    localparam int unsigned WORD_IDX_W       = 3;
    localparam int unsigned DIGIT_W          = 7;
    localparam int unsigned WORD_W           = 32;
    localparam int unsigned PAGE_W           = 16;
    localparam int unsigned POS_W            = 3;
    localparam int unsigned IDX_W            = 4;

    // Result kinds as they appear on the output port.
    localparam logic [1:0] KIND_LEAF = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] BYTE_END   = 8'h00;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    typedef enum logic [1:0] {
        TOK_DIGIT = 2'd0,
        TOK_SPACE = 2'd1,
        TOK_END   = 2'd2,
        TOK_BAD   = 2'd3
    } tok_kind_t;

    // One classified text byte as it travels from the front to the back.
    typedef struct packed {
        tok_kind_t            kind;
        logic [DIGIT_W-1:0]   digit;
    } token_t;

    // Returns the digit value in the low bits and a hit flag in the top bit.
    function automatic logic [DIGIT_W:0] digit_of(input logic [7:0] b);
        logic [DIGIT_W:0] r;
        r = '0;
        if (b == 8'h21)                    r = {1'b1, 7'd0};
        else if (b >= 8'h23 && b <= 8'h26) r = {1'b1, 7'(b - 8'h23 + 8'd1)};
        else if (b >= 8'h28 && b <= 8'h2b) r = {1'b1, 7'(b - 8'h28 + 8'd5)};
        else if (b >= 8'h2e && b <= 8'h39) r = {1'b1, 7'(b - 8'h2e + 8'd9)};
        else if (b == 8'h3b)               r = {1'b1, 7'd21};
        else if (b == 8'h3c)               r = {1'b1, 7'd22};
        else if (b == 8'h3e)               r = {1'b1, 7'd23};
        else if (b == 8'h3f)               r = {1'b1, 7'd24};
        else if (b >= 8'h40 && b <= 8'h5b) r = {1'b1, 7'(b - 8'h40 + 8'd25)};
        else if (b == 8'h5d)               r = {1'b1, 7'd53};
        else if (b == 8'h5e)               r = {1'b1, 7'd54};
        else if (b >= 8'h61 && b <= 8'h7e) r = {1'b1, 7'(b - 8'h61 + 8'd55)};
        return r;
    endfunction

endpackage

[rtl/charset_base85_record_decoder.sv]
// ----------------------------------------------------------------------------
// charset_base85_record_decoder
// Decodes base-85 charset text into leaf records with page and bitmap words,
// and into OK or error status results.
// The decoder takes one text byte per cycle and sustains that rate as long as
// results are taken; a token is registered in the queue, then a result in the back.
// The front classifies each byte against the digit alphabet and writes a
// token into a queue of QUEUE_DEPTH entries; the back runs the value and
// record assembly, one token per cycle through a single multiply-by-85 adder,
// and holds one result in its output register. While that register waits on
// m_ready the back pauses and the queue keeps taking bytes until it fills.
// ----------------------------------------------------------------------------
module charset_base85_record_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [15:0] m_page,
    output logic [31:0] m_map_word0,
    output logic [31:0] m_map_word1,
    output logic [31:0] m_map_word2,
    output logic [31:0] m_map_word3,
    output logic [31:0] m_map_word4,
    output logic [31:0] m_map_word5,
    output logic [31:0] m_map_word6,
    output logic [31:0] m_map_word7
);
    import cb85_pkg::*;

    logic        push_valid;
    logic        push_ready;
    token_t      push_token;
    logic        pop_valid;
    logic        pop_ready;
    token_t      pop_token;
    logic [31:0] map_word [WORDS_PER_RECORD];

    cb85_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_token  (push_token)
    );

    cb85_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_token (push_token),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_token  (pop_token)
    );

    cb85_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_token     (pop_token),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_page        (m_page),
        .m_map_word    (map_word)
    );

    assign m_map_word0 = map_word[0];
    assign m_map_word1 = map_word[1];
    assign m_map_word2 = map_word[2];
    assign m_map_word3 = map_word[3];
    assign m_map_word4 = map_word[4];
    assign m_map_word5 = map_word[5];
    assign m_map_word6 = map_word[6];
    assign m_map_word7 = map_word[7];

endmodule

[rtl/cb85_front.sv]
// ----------------------------------------------------------------------------
// cb85_front
// Accepts text bytes and classifies each one into a token for the queue.
// ----------------------------------------------------------------------------
module cb85_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_text_byte,
    output logic                 push_valid,
    input  logic                 push_ready,
    output cb85_pkg::token_t     push_token
);
    import cb85_pkg::*;

    logic [DIGIT_W:0] lookup;

    assign lookup     = digit_of(s_text_byte);
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_token.digit = lookup[DIGIT_W-1:0];
        if (s_text_byte == BYTE_END) begin
            push_token.kind = TOK_END;
        end else if (s_text_byte == BYTE_SPACE) begin
            push_token.kind = TOK_SPACE;
        end else if (lookup[DIGIT_W]) begin
            push_token.kind = TOK_DIGIT;
        end else begin
            push_token.kind = TOK_BAD;
        end
    end

endmodule

[rtl/cb85_queue.sv]
// ----------------------------------------------------------------------------
// cb85_queue
// Short token queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module cb85_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  cb85_pkg::token_t     push_token,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output cb85_pkg::token_t     pop_token
);
    import cb85_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    token_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_token  = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_ptr_reg] <= push_token;
        end
    end

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push_fire && !pop_fire |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on a lone push");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_fire && !push_fire |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on a lone pop");

endmodule

[rtl/cb85_back.sv]
// ----------------------------------------------------------------------------
// cb85_back
// Assembles values and records from tokens and registers one result at a time.
// ----------------------------------------------------------------------------
module cb85_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  cb85_pkg::token_t     pop_token,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_result_kind,
    output logic [15:0]          m_page,
    output logic [31:0]          m_map_word [cb85_pkg::WORDS_PER_RECORD]
);
    import cb85_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS_PER_VALUE - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS_PER_RECORD);

    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] code_reg, code_next;
    logic [WORD_W-1:0] words_reg [WORDS_PER_RECORD];
    logic              any_reg, any_next;
    logic              err_reg, err_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [WORD_W-1:0] map_reg [WORDS_PER_RECORD];
    logic [WORD_W-1:0] map_next [WORDS_PER_RECORD];

    logic              pop_fire;
    logic [WORD_W-1:0] acc_mac;
    logic              value_done;
    logic [WORD_W-1:0] value_word;
    logic              word_wr;
    logic [WORD_IDX_W-1:0] word_sel;
    logic              emit;

    assign pop_ready = !out_valid_reg || m_ready;
    assign pop_fire  = pop_valid && pop_ready;

    // acc * 85 as shifted adds, plus the new digit; wraps at 32 bits.
    assign acc_mac = (acc_reg << 6) + (acc_reg << 4) + (acc_reg << 2) + acc_reg
                   + {{(WORD_W-DIGIT_W){1'b0}}, pop_token.digit};
    assign word_sel = WORD_IDX_W'(idx_reg - 1'b1);

    always_comb begin
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        code_next      = code_reg;
        any_next       = any_reg;
        err_next       = err_reg;
        value_done     = 1'b0;
        value_word     = '0;
        word_wr        = 1'b0;
        emit           = 1'b0;
        kind_next      = kind_reg;
        page_next      = page_reg;
        for (int i = 0; i < WORDS_PER_RECORD; i++) begin
            map_next[i] = map_reg[i];
        end

        if (pop_fire) begin
            if (pop_token.kind == TOK_END) begin
                acc_next  = '0;
                pos_next  = '0;
                idx_next  = '0;
                code_next = '0;
                any_next  = 1'b0;
                err_next  = 1'b0;
                if (!err_reg) begin
                    emit      = 1'b1;
                    kind_next = (idx_reg == '0 && pos_reg == '0) ? KIND_OK : KIND_ERR;
                end
            end else if (err_reg) begin
                // Dropping bytes until the end of the text.
            end else if (pop_token.kind == TOK_BAD
                         || (pop_token.kind == TOK_SPACE && pos_reg != '0)) begin
                acc_next  = '0;
                pos_next  = '0;
                idx_next  = '0;
                code_next = '0;
                any_next  = 1'b0;
                err_next  = 1'b1;
                emit      = 1'b1;
                kind_next = KIND_ERR;
            end else if (pop_token.kind == TOK_SPACE) begin
                value_done = 1'b1;
            end else begin
                acc_next   = acc_mac;
                pos_next   = pos_reg + 1'b1;
                value_word = acc_mac;
                value_done = (pos_reg == LAST_POS);
            end

            if (value_done) begin
                acc_next = '0;
                pos_next = '0;
                if (idx_reg == '0) begin
                    code_next = value_word;
                    idx_next  = IDX_W'(1);
                end else if (idx_reg != LAST_IDX) begin
                    word_wr  = 1'b1;
                    any_next = any_reg || (value_word != '0);
                    idx_next = idx_reg + 1'b1;
                end else begin
                    // Last word completes the record.
                    idx_next  = '0;
                    code_next = '0;
                    any_next  = 1'b0;
                    if (any_reg || value_word != '0) begin
                        emit = 1'b1;
                        if (code_reg[WORD_W-1:PAGE_W+8] != '0) begin
                            err_next  = 1'b1;
                            kind_next = KIND_ERR;
                        end else begin
                            kind_next = KIND_LEAF;
                        end
                    end
                end
            end

            if (emit) begin
                page_next = '0;
                for (int i = 0; i < WORDS_PER_RECORD; i++) begin
                    map_next[i] = '0;
                end
                if (kind_next == KIND_LEAF) begin
                    page_next = code_reg[PAGE_W+7:8];
                    for (int i = 0; i < WORDS_PER_RECORD; i++) begin
                        map_next[i] = (i == WORDS_PER_RECORD - 1) ? value_word : words_reg[i];
                    end
                end
            end
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            code_reg      <= '0;
            any_reg       <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            code_reg      <= code_next;
            any_reg       <= any_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (word_wr) begin
            words_reg[word_sel] <= value_word;
        end
        kind_reg <= kind_next;
        page_reg <= page_next;
        for (int i = 0; i < WORDS_PER_RECORD; i++) begin
            map_reg[i] <= map_next[i];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_page        = page_reg;
    always_comb begin
        for (int i = 0; i < WORDS_PER_RECORD; i++) begin
            m_map_word[i] = map_reg[i];
        end
    end

    a_end_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_fire && pop_token.kind == TOK_END && !err_reg
        |=> out_valid_reg && (kind_reg == KIND_OK || kind_reg == KIND_ERR))
        else $error("end of text without a status result");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> idx_reg == '0 && pos_reg == '0 && !any_reg)
        else $error("record state left over while dropping after an error");

endmodule
